// ===== hw/rtl/fsdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdr_pkg
// Shared types and constants for the first-seen dense relabelling block.
// ----------------------------------------------------------------------------
package fsdr_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int IN_KEY_W      = 32;
  localparam int LABEL_W       = 6;

  typedef struct packed {
    logic [IN_KEY_W-1:0] key;
    logic                start_sequence;
  } fsdr_in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               is_new;
    logic               overflow;
  } fsdr_out_t;

  // Control that travels with a key as it walks along the cell chain.
  typedef struct packed {
    logic valid;
    logic hit;
  } fsdr_probe_t;

endpackage

// ===== hw/rtl/fsdr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdr_cell
// One stored key of the chain; compares a passing probe against it and hands
// the probe, its key and the first matching index on to the next cell.
// ----------------------------------------------------------------------------
module fsdr_cell #(
  parameter int CAPACITY  = fsdr_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = fsdr_pkg::KEY_WIDTH_DEF,
  parameter int CELL_IDX  = 0,
  localparam int IDX_W    = $clog2(CAPACITY),
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CNT_W-1:0]      count,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [KEY_WIDTH-1:0]  wr_key,
  input  fsdr_pkg::fsdr_probe_t probe_in,
  input  logic [KEY_WIDTH-1:0]  key_in,
  input  logic [IDX_W-1:0]      idx_in,
  output fsdr_pkg::fsdr_probe_t probe_out,
  output logic [KEY_WIDTH-1:0]  key_out,
  output logic [IDX_W-1:0]      idx_out
);

  logic [KEY_WIDTH-1:0]  entry_r;
  fsdr_pkg::fsdr_probe_t probe_r, probe_nxt;
  logic [KEY_WIDTH-1:0]  key_r;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  live;
  logic                  match;

  // The entry holds a key only once the fill count has passed this cell.
  assign live  = CNT_W'(CELL_IDX) < count;
  assign match = probe_in.valid && live && (entry_r == key_in);

  always_comb begin
    probe_nxt.valid = probe_in.valid;
    probe_nxt.hit   = probe_in.hit | match;
    idx_nxt         = probe_in.hit ? idx_in : IDX_W'(CELL_IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
    key_r <= key_in;
    idx_r <= idx_nxt;
    if (wr_en && wr_idx == IDX_W'(CELL_IDX)) begin
      entry_r <= wr_key;
    end
  end

  assign probe_out = probe_r;
  assign key_out   = key_r;
  assign idx_out   = idx_r;

endmodule

// ===== hw/rtl/first_seen_dense_relabel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_seen_dense_relabel
// Replaces each key with a dense label in order of first appearance.
// ----------------------------------------------------------------------------
// Usage: drive in_data and raise start; the transfer happens at a clock edge
// where start is high and busy is low. in_data.start_sequence empties the
// store of seen keys before that key is looked up.
// The key enters a chain of CAPACITY cells, one stored key per cell, and
// moves one cell per cycle; each cell compares it with its own entry. When
// the probe leaves the last cell the label is decided, a new key is written
// into the next free cell and the result is shown on out_data with out_valid
// high for exactly one cycle. The receiver cannot stall the block, so the
// result must be taken in that cycle.
// out_valid is registered from the decision made as the probe leaves the last
// cell. No new key is taken until then: the probe's walk along the cell chain
// sets the pace, and busy is high for the whole walk.
// A full store answers a new key with overflow set and label 0, and stores
// nothing. Reset (rst_n low, synchronous) empties the store and clears busy;
// stored keys themselves are not cleared, the fill count guards them.
// ----------------------------------------------------------------------------
module first_seen_dense_relabel #(
  parameter int CAPACITY  = fsdr_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = fsdr_pkg::KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fsdr_pkg::fsdr_in_t  in_data,
  output logic                out_valid,
  output fsdr_pkg::fsdr_out_t out_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {S_IDLE, S_SEARCH} state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 tok_valid_r, tok_valid_nxt;
  logic [KEY_WIDTH-1:0] tok_key_r, tok_key_nxt;
  logic                 out_valid_r, out_valid_nxt;
  fsdr_pkg::fsdr_out_t  out_data_r, out_data_nxt;
  logic                 wr_en;
  logic                 accept;

  fsdr_pkg::fsdr_probe_t chain_probe [CAPACITY+1];
  logic [KEY_WIDTH-1:0]  chain_key   [CAPACITY+1];
  logic [IDX_W-1:0]      chain_idx   [CAPACITY+1];

  assign accept = start && (state_r == S_IDLE);

  assign chain_probe[0].valid = tok_valid_r;
  assign chain_probe[0].hit   = 1'b0;
  assign chain_key[0]         = tok_key_r;
  assign chain_idx[0]         = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    fsdr_cell #(
      .CAPACITY (CAPACITY),
      .KEY_WIDTH(KEY_WIDTH),
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .count    (count_r),
      .wr_en    (wr_en),
      .wr_idx   (count_r[IDX_W-1:0]),
      .wr_key   (chain_key[CAPACITY]),
      .probe_in (chain_probe[g]),
      .key_in   (chain_key[g]),
      .idx_in   (chain_idx[g]),
      .probe_out(chain_probe[g+1]),
      .key_out  (chain_key[g+1]),
      .idx_out  (chain_idx[g+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    tok_valid_nxt = 1'b0;
    tok_key_nxt   = tok_key_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          tok_valid_nxt = 1'b1;
          tok_key_nxt   = KEY_WIDTH'(in_data.key);
          if (in_data.start_sequence) begin
            count_nxt = '0;
          end
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (chain_probe[CAPACITY].valid) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (chain_probe[CAPACITY].hit) begin
            out_data_nxt.label    = fsdr_pkg::LABEL_W'(chain_idx[CAPACITY]);
            out_data_nxt.is_new   = 1'b0;
            out_data_nxt.overflow = 1'b0;
          end else if (count_r < CNT_W'(CAPACITY)) begin
            wr_en                 = 1'b1;
            count_nxt             = count_r + CNT_W'(1);
            out_data_nxt.label    = fsdr_pkg::LABEL_W'(count_r[IDX_W-1:0]);
            out_data_nxt.is_new   = 1'b1;
            out_data_nxt.overflow = 1'b0;
          end else begin
            out_data_nxt.label    = '0;
            out_data_nxt.is_new   = 1'b1;
            out_data_nxt.overflow = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tok_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tok_valid_r <= tok_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tok_key_r  <= tok_key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The store never holds more keys than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("key count beyond capacity");

  // Every walk along the chain ends in exactly one result.
  a_result_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("search finished without a result");

  // A transfer cannot produce a result in the very next cycle.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_valid)
    else $error("result appeared too early");

  // Overflow is reported only for a new key against a full store.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |->
      (out_data.is_new && out_data.label == '0 && count_r == CNT_W'(CAPACITY)))
    else $error("overflow reported with room in the store");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for first_seen_dense_relabel.
// ----------------------------------------------------------------------------
// A short table of directed keys comes first: the extremes, repeats and new
// sequences, some with their labels written in by hand. A long random run
// follows. It is made mostly of well-formed sequences drawn from small pools
// of keys, with regular runs that fill the store past its capacity. A little
// noise is mixed in. Each transfer without a hand-written label is labelled by
// a local copy of the store; every result is compared, field by field, with
// the result strobe. The sender idles at three different rates in turn.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CAPACITY     = fsdr_pkg::CAPACITY_DEF;
  localparam int KEY_W        = fsdr_pkg::KEY_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic [fsdr_pkg::IN_KEY_W-1:0] key;
    logic                          start_sequence;
    logic                          typed;
    logic [fsdr_pkg::LABEL_W-1:0]  label;
    logic                          is_new;
    logic                          overflow;
  } key_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  fsdr_pkg::fsdr_in_t  in_data = '0;
  logic                out_valid;
  fsdr_pkg::fsdr_out_t out_data;

  // Local copy of the store of seen keys.
  logic [KEY_W-1:0] seen_store [CAPACITY];
  int               seen_count = 0;

  fsdr_pkg::fsdr_out_t pending_labels [$];
  int        idle_pct = 0;
  int        n_errors = 0;
  int        n_transfers = 0;
  int        n_new = 0;
  int        n_overflow = 0;
  int        n_starts = 0;
  int        n_results = 0;
  longint    cycles = 0;

  first_seen_dense_relabel #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic fsdr_pkg::fsdr_out_t relabel_key(input fsdr_pkg::fsdr_in_t item);
    fsdr_pkg::fsdr_out_t res;
    logic [KEY_W-1:0]    k;
    bit                  found;
    int                  idx;
    int                  i;
    res = '0;
    k = item.key[KEY_W-1:0];
    found = 1'b0;
    idx = 0;
    if (item.start_sequence)
      seen_count = 0;
    for (i = 0; i < seen_count; i++) begin
      if (!found && seen_store[i] == k) begin
        found = 1'b1;
        idx = i;
      end
    end
    if (found) begin
      res.label = fsdr_pkg::LABEL_W'(idx);
    end else begin
      res.is_new = 1'b1;
      if (seen_count < CAPACITY) begin
        seen_store[seen_count] = k;
        res.label = fsdr_pkg::LABEL_W'(seen_count);
        seen_count++;
      end else begin
        res.overflow = 1'b1;
      end
    end
    return res;
  endfunction

  // Offers one key and returns at the edge where it was taken. With drain set,
  // the sender holds off until every outstanding result has come back.
  task automatic offer_key(input logic [fsdr_pkg::IN_KEY_W-1:0] key, input logic seq_start,
                           input bit drain, input bit typed,
                           input fsdr_pkg::fsdr_out_t typed_res);
    int                  gap;
    fsdr_pkg::fsdr_in_t  item;
    fsdr_pkg::fsdr_out_t res;
    gap = 0;
    if ($urandom_range(99) < idle_pct)
      gap = ($urandom_range(7) == 0) ? $urandom_range(1, 2 * CAPACITY) : $urandom_range(1, 4);
    if (drain && gap == 0)
      gap = 1;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain && pending_labels.size() != 0) @(posedge clk);
    end
    item.key = key;
    item.start_sequence = seq_start;
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = relabel_key(item);
    if (typed)
      res = typed_res;
    pending_labels.push_back(res);
    n_transfers++;
    n_new += res.is_new;
    n_overflow += res.overflow;
    n_starts += seq_start;
  endtask

  // Results are sampled at the edge that ends their single strobe cycle.
  always @(posedge clk) begin
    fsdr_pkg::fsdr_out_t want;
    if (rst_n && out_valid) begin
      n_results <= n_results + 1;
      if (pending_labels.size() == 0) begin
        $error("result with no transfer outstanding: label %0d", out_data.label);
        n_errors++;
      end else begin
        want = pending_labels.pop_front();
        if (out_data.label !== want.label) begin
          $error("label: expected %0d, got %0d", want.label, out_data.label);
          n_errors++;
        end
        if (out_data.is_new !== want.is_new) begin
          $error("is_new: expected %0d, got %0d", want.is_new, out_data.is_new);
          n_errors++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_data.overflow);
          n_errors++;
        end
      end
    end
  end

  initial begin
    key_row_t                      key_rows [$];
    logic [fsdr_pkg::IN_KEY_W-1:0] pool [$];
    logic [fsdr_pkg::IN_KEY_W-1:0] key;
    fsdr_pkg::fsdr_out_t           typed_res;
    int                            i;
    int                            k;
    int                            mode;
    int                            pool_size;
    int                            next_fresh;
    int                            seq_len;
    int                            seq_no;
    int                            rand_sent;
    int                            phase;
    int                            last_phase;
    bit                            drain;

    // Fields: key, start of sequence, typed, label, is_new, overflow.
    key_rows.push_back({32'h0000_0000, 1'b0, 1'b1, 6'd0, 1'b1, 1'b0});
    key_rows.push_back({32'hFFFF_FFFF, 1'b0, 1'b1, 6'd1, 1'b1, 1'b0});
    key_rows.push_back({32'h0000_0000, 1'b0, 1'b1, 6'd0, 1'b0, 1'b0});
    key_rows.push_back({32'h8000_0000, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0});
    key_rows.push_back({32'h7FFF_FFFF, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0});
    key_rows.push_back({32'hFFFF_FFFE, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0});
    key_rows.push_back({32'hFFFF_FFFF, 1'b0, 1'b1, 6'd1, 1'b0, 1'b0});
    key_rows.push_back({32'h0000_0001, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0});
    key_rows.push_back({32'h8000_0000, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0});
    key_rows.push_back({32'hFFFF_FFFF, 1'b1, 1'b1, 6'd0, 1'b1, 1'b0});
    key_rows.push_back({32'hFFFF_FFFF, 1'b0, 1'b1, 6'd0, 1'b0, 1'b0});
    key_rows.push_back({32'h0000_0000, 1'b0, 1'b1, 6'd1, 1'b1, 1'b0});
    key_rows.push_back({32'h1234_5678, 1'b1, 1'b1, 6'd0, 1'b1, 1'b0});
    key_rows.push_back({32'h1234_5678, 1'b1, 1'b1, 6'd0, 1'b1, 1'b0});
    key_rows.push_back({32'hA5A5_A5A5, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0});
    key_rows.push_back({32'h5A5A_5A5A, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0});
    key_rows.push_back({32'h1234_5678, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0});
    key_rows.push_back({32'hA5A5_A5A5, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0});
    key_rows.push_back({32'h0000_0000, 1'b1, 1'b1, 6'd0, 1'b1, 1'b0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < key_rows.size(); i++) begin
      typed_res.label = key_rows[i].label;
      typed_res.is_new = key_rows[i].is_new;
      typed_res.overflow = key_rows[i].overflow;
      offer_key(key_rows[i].key, key_rows[i].start_sequence, 1'b0, key_rows[i].typed,
                typed_res);
    end

    rand_sent = 0;
    seq_no = 0;
    last_phase = -1;
    while (rand_sent < RANDOM_ITEMS) begin
      mode = $urandom_range(99);
      if (seq_no % 5 == 0)
        mode = 0;

      // Pools mix unrelated keys with near neighbours one bit apart.
      pool.delete();
      if (mode < 8)
        pool_size = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      else
        pool_size = $urandom_range(1, 20);
      for (k = 0; k < pool_size; k++) begin
        if (k > 0 && $urandom_range(3) == 0)
          key = pool[$urandom_range(0, k - 1)] ^ (32'h1 << $urandom_range(31));
        else
          key = $urandom;
        pool.push_back(key);
      end
      if (mode < 8)
        seq_len = pool_size + $urandom_range(2, 20);
      else if (mode < 88)
        seq_len = $urandom_range(3, 40);
      else
        seq_len = $urandom_range(1, 10);

      next_fresh = 0;
      for (k = 0; k < seq_len && rand_sent < RANDOM_ITEMS; k++) begin
        phase = rand_sent * 3 / RANDOM_ITEMS;
        drain = (phase != last_phase);
        if (drain) begin
          last_phase = phase;
          idle_pct = (phase == 0) ? 19 : (phase == 1) ? 82 : 0;
        end
        if (mode >= 88) begin
          // Noise: unrelated keys with sequence starts at random.
          offer_key($urandom, ($urandom_range(3) == 0), drain, 1'b0, '0);
        end else if (mode < 8) begin
          // Walk the pool in order so the store fills, with repeats between.
          if (next_fresh < pool_size && (k == 0 || $urandom_range(4) != 0)) begin
            key = pool[next_fresh];
            next_fresh++;
          end else begin
            key = pool[$urandom_range(0, pool_size - 1)];
          end
          offer_key(key, (k == 0), drain, 1'b0, '0);
        end else begin
          offer_key(pool[$urandom_range(0, pool_size - 1)], (k == 0), drain, 1'b0, '0);
        end
        rand_sent++;
      end
      seq_no++;
    end

    start <= 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    $display("Relabelled %0d keys over %0d random sequences: %0d new, %0d overflows,",
             n_transfers, seq_no, n_new, n_overflow);
    $display("%0d sequence starts; the sender idled at 19, 82 and 0 percent in turn.",
             n_starts);
    if (n_errors == 0 && pending_labels.size() == 0 && n_results == n_transfers) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fsdr_pkg.sv
hw/rtl/fsdr_cell.sv
hw/rtl/first_seen_dense_relabel.sv
sim/testbench.sv
